// ===== hdl/utf8_to_rtf_unicode_escape_core_macros.svh =====
// assertion macros shared by the converter rtl
// no dependencies; taken in by the modules that check their own logic
`ifndef UTF8_TO_RTF_UNICODE_ESCAPE_CORE_MACROS_SVH
`define UTF8_TO_RTF_UNICODE_ESCAPE_CORE_MACROS_SVH

// condition holds on every edge out of reset
`define U2RTF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define U2RTF_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define U2RTF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/u2rtf_pkg.sv =====
// shared types, character codes and decimal helpers for the converter
// no dependencies
package u2rtf_pkg;

   // work handed from the byte front end to the text back end
   typedef struct packed {
      logic        is_code;   // 0: plain character in g1[7:0]
      logic        pair;      // two escape groups
      logic [15:0] g1;
      logic [15:0] g2;
   } job_type;

   typedef struct packed {
      logic [3:0]  digit;
      logic [16:0] sub;
   } digit_type;

   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // high surrogate: ((cp >> 10) - 0x40 + 0xd800) cut to 16 bits
   localparam logic [15:0] HI_OFFSET = 16'hD7C0;
   // low surrogate: 0xdc00 | cp[9:0]
   localparam logic [5:0]  LO_PREFIX = 6'b110111;

   function automatic logic [16:0] pow10_of(input logic [2:0] pos);
      logic [16:0] p;
      unique case (pos)
         3'd0:    p = 17'd1;
         3'd1:    p = 17'd10;
         3'd2:    p = 17'd100;
         3'd3:    p = 17'd1000;
         3'd4:    p = 17'd10000;
         default: p = 17'd1;
      endcase
      return p;
   endfunction

   // one decimal digit at position pos, by parallel compares against its multiples
   function automatic digit_type digit_pick(input logic [15:0] rem, input logic [2:0] pos);
      digit_type   r;
      logic [16:0] thr;
      r.digit = 4'd0;
      r.sub   = 17'd0;
      for (int k = 1; k <= 9; k++) begin
         thr = 17'(pow10_of(pos) * k);
         if (17'(rem) >= thr) begin
            r.digit = 4'(k);
            r.sub   = thr;
         end
      end
      return r;
   endfunction

endpackage

// ===== hdl/u2rtf_front.sv =====
// byte front end: sequence tracking, code point gathering, job forming
// depends on u2rtf_pkg
module u2rtf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [7:0]        req_in_byte,
   input  logic              q_full,
   output logic              job_push,
   output u2rtf_pkg::job_type job
);
   import u2rtf_pkg::*;

   logic [2:0]  pending_ff, pending_in;
   logic [35:0] acc_ff, acc_in;
   logic [35:0] acc_shift;
   logic [15:0] hi_group;
   logic        pair;
   logic        accept;

   always_comb begin
      accept     = req_push & ~q_full;
      acc_shift  = {acc_ff[29:0], req_in_byte[5:0]};
      hi_group   = acc_shift[25:10] + HI_OFFSET;
      pair       = |acc_shift[35:16];
      pending_in = pending_ff;
      acc_in     = acc_ff;
      job_push   = 1'b0;
      job        = '0;
      if (accept) begin
         if (pending_ff != 3'd0) begin
            // any byte counts as continuation
            pending_in = pending_ff - 3'd1;
            if (pending_ff == 3'd1) begin
               job_push    = 1'b1;
               job.is_code = 1'b1;
               job.pair    = pair;
               job.g1      = pair ? hi_group : acc_shift[15:0];
               job.g2      = {LO_PREFIX, acc_shift[9:0]};
               acc_in      = '0;
            end else begin
               acc_in = acc_shift;
            end
         end else if (!req_in_byte[7]) begin
            job_push = 1'b1;
            job.g1   = {8'h00, req_in_byte};
         end else if (req_in_byte[6]) begin
            // lead byte, stray continuation falls through and is dropped
            if (!req_in_byte[5]) begin
               pending_in = 3'd1;
               acc_in     = {31'd0, req_in_byte[4:0]};
            end else if (!req_in_byte[4]) begin
               pending_in = 3'd2;
               acc_in     = {32'd0, req_in_byte[3:0]};
            end else if (!req_in_byte[3]) begin
               pending_in = 3'd3;
               acc_in     = {33'd0, req_in_byte[2:0]};
            end else if (!req_in_byte[2]) begin
               pending_in = 3'd4;
               acc_in     = {34'd0, req_in_byte[1:0]};
            end else if (!req_in_byte[1]) begin
               pending_in = 3'd5;
               acc_in     = {35'd0, req_in_byte[0]};
            end else begin
               pending_in = 3'd6;
               acc_in     = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
         acc_ff     <= '0;
      end else begin
         pending_ff <= pending_in;
         acc_ff     <= acc_in;
      end
   end

endmodule

// ===== hdl/u2rtf_queue.sv =====
// job queue between front and back end, register slots
// depends on u2rtf_pkg and the assertion macro header
`include "utf8_to_rtf_unicode_escape_core_macros.svh"
module u2rtf_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u2rtf_pkg::job_type push_job,
   input  logic              pop,
   output u2rtf_pkg::job_type pop_job,
   output logic              empty,
   output logic              full
);
   import u2rtf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      empty    = (count_ff == CNT_W'(0));
      full     = (count_ff == CNT_W'(DEPTH));
      pop_job  = slot_ff[head_ff];
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : tail_ff + PTR_W'(1);
      end
      if (pop) begin
         head_in = (head_ff == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : head_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   `U2RTF_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `U2RTF_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "queue count missed a push")
   `U2RTF_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - CNT_W'(1), "queue count missed a pop")

endmodule

// ===== hdl/u2rtf_back.sv =====
// text back end: escape sequencer, decimal digits, output register
// depends on u2rtf_pkg and the assertion macro header
`include "utf8_to_rtf_unicode_escape_core_macros.svh"
module u2rtf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  u2rtf_pkg::job_type q_job,
   output logic              q_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_run_last
);
   import u2rtf_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_BSL   = 6'b000010,
      ST_U     = 6'b000100,
      ST_MINUS = 6'b001000,
      ST_DIGIT = 6'b010000,
      ST_QMARK = 6'b100000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] bits_ff, bits_in;
   logic [15:0] second_ff, second_in;
   logic        pair_ff, pair_in;
   logic [15:0] rem_ff, rem_in;
   logic [2:0]  pos_ff, pos_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_char_ff, out_char_in;
   logic        out_last_ff, out_last_in;

   logic        adv, emit, last, neg;
   logic [7:0]  ch;
   logic [15:0] mag;
   logic [2:0]  start_pos;
   digit_type   dig;

   always_comb begin
      adv = !out_valid_ff || rsp_pop;
      neg = bits_ff[15];
      mag = neg ? (16'd0 - bits_ff) : bits_ff;
      start_pos = 3'd0;
      if (mag >= 16'd10)    start_pos = 3'd1;
      if (mag >= 16'd100)   start_pos = 3'd2;
      if (mag >= 16'd1000)  start_pos = 3'd3;
      if (mag >= 16'd10000) start_pos = 3'd4;
      dig = digit_pick(rem_ff, pos_ff);

      emit      = 1'b0;
      last      = 1'b0;
      ch        = CH_BSL;
      q_pop     = 1'b0;
      phase_in  = phase_ff;
      bits_in   = bits_ff;
      second_in = second_ff;
      pair_in   = pair_ff;
      rem_in    = rem_ff;
      pos_in    = pos_ff;

      if (adv) begin
         unique case (phase_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  q_pop = 1'b1;
                  emit  = 1'b1;
                  if (q_job.is_code) begin
                     ch        = CH_BSL;
                     bits_in   = q_job.g1;
                     second_in = q_job.g2;
                     pair_in   = q_job.pair;
                     phase_in  = ST_U;
                  end else begin
                     ch   = q_job.g1[7:0];
                     last = 1'b1;
                  end
               end
            end
            ST_BSL: begin
               emit     = 1'b1;
               ch       = CH_BSL;
               phase_in = ST_U;
            end
            ST_U: begin
               emit     = 1'b1;
               ch       = CH_U;
               rem_in   = mag;
               pos_in   = start_pos;
               phase_in = neg ? ST_MINUS : ST_DIGIT;
            end
            ST_MINUS: begin
               emit     = 1'b1;
               ch       = CH_MINUS;
               phase_in = ST_DIGIT;
            end
            ST_DIGIT: begin
               emit   = 1'b1;
               ch     = CH_ZERO + {4'd0, dig.digit};
               rem_in = 16'(17'(rem_ff) - dig.sub);
               if (pos_ff == 3'd0) begin
                  phase_in = ST_QMARK;
               end else begin
                  pos_in = pos_ff - 3'd1;
               end
            end
            ST_QMARK: begin
               emit = 1'b1;
               ch   = CH_QMARK;
               last = !pair_ff;
               if (pair_ff) begin
                  bits_in  = second_ff;
                  pair_in  = 1'b0;
                  phase_in = ST_BSL;
               end else begin
                  phase_in = ST_IDLE;
               end
            end
            default: phase_in = ST_IDLE;
         endcase
      end

      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      if (adv) begin
         out_valid_in = emit;
         out_char_in  = ch;
         out_last_in  = last;
      end

      rsp_empty    = !out_valid_ff;
      rsp_out_char = out_char_ff;
      rsp_run_last = out_last_ff;
   end

   always_ff @(posedge clock) begin
      bits_ff     <= bits_in;
      second_ff   <= second_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_IDLE;
         pair_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pair_ff      <= pair_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `U2RTF_ASSERT_IMPLY(a_digit_range, clock, reset, phase_ff == ST_DIGIT, (pos_ff <= 3'd4) && (17'(rem_ff) < 17'(pow10_of(pos_ff) * 17'd10)), "digit remainder out of range")
   `U2RTF_ASSERT_IMPLY(a_second_group, clock, reset, phase_ff == ST_BSL, !pair_ff, "second group started with pair still set")
   `U2RTF_ASSERT_NEXT(a_close_last, clock, reset, adv && phase_ff == ST_QMARK && !pair_ff, out_valid_ff && out_last_ff && (out_char_ff == CH_QMARK), "closing mark not flagged last")

endmodule

// ===== hdl/utf8_to_rtf_unicode_escape_core.sv =====
// channel   ports                                direction  moves
// req       req_push, req_full, req_in_byte       in         one utf-8 byte per word
// rsp       rsp_pop, rsp_empty, rsp_out_char,     out        one text character per word,
//           rsp_run_last                                     last flag on final one per code point
//
// top level of the utf-8 to rtf unicode escape converter
// depends on u2rtf_pkg, u2rtf_front, u2rtf_queue, u2rtf_back
//
// cycles: the front end takes one byte per cycle while the job queue has room; the back
//   end sends one character per cycle while rsp_pop takes each one, so an ascii byte becomes
//   a single character and a code point the characters of its escape text
// the back end's one-character-per-cycle sequencer sets the sustained rate
// reset: synchronous, clears the sequence state, queue pointers and output valid flag
// stalls: rsp_pop low holds the output word; the queue then fills and raises req_full
module utf8_to_rtf_unicode_escape_core #(
   parameter int QUEUE_DEPTH = 4   // jobs between front and back end, 2 or more
) (
   input  logic       clock,
   input  logic       reset,
   // byte input, queue style
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   // character output, queue style
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_char,
   output logic       rsp_run_last
);
   import u2rtf_pkg::*;

   // front to queue
   logic    job_push;
   job_type job;
   // queue to back
   job_type q_job;
   logic    q_pop;
   logic    q_empty;
   logic    q_full;

   // front end: tracks pending continuations and gathers the code point;
   // a finished code point leaves as one job with its surrogate groups already formed
   u2rtf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .job_push    (job_push),
      .job         (job)
   );

   // short job queue so the byte side and text side stall on their own
   u2rtf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .pop_job  (q_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // back end: walks backslash, u, sign, digits, question mark for each group;
   // digits come most significant first, one per cycle while rsp_pop takes them, leading zeros skipped
   u2rtf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_job        (q_job),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_char (rsp_out_char),
      .rsp_run_last (rsp_run_last)
   );

   // every byte, even one with no text, waits for a free queue slot
   assign req_full = q_full;

endmodule
